[rtl/ggrw_pkg.sv]
// Shared types, constants and control structs of the greedy gradient route walk.
package ggrw_pkg;

	localparam int GRID_W_DEF     = 32;
	localparam int GRID_H_DEF     = 32;
	localparam int VALUE_BITS_DEF = 16;
	localparam int MAX_SIDE       = 32;
	localparam int CENTER_K       = 4;
	localparam int LAST_K         = 8;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PLAN = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [4:0]         cell_x;
		logic [4:0]         cell_y;
		logic signed [15:0] gradient_value;
		logic [4:0]         start_x;
		logic [4:0]         start_y;
		logic [4:0]         target_x;
		logic [4:0]         target_y;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  row_index;
		logic [31:0] row_bits;
		logic        last_row;
		logic        reached_target;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic plan;
		logic mark;
		logic set_reached;
		logic scan_start;
		logic scan_step;
		logic move;
		logic emit_load;
	} ctl_t;

	typedef struct packed {
		logic at_target;
		logic limit_hit;
		logic scan_last;
		logic row_last;
	} sts_t;

	// offset of neighbour k, x outer and y inner, each -1..+1
	function automatic logic signed [1:0] dx_of(input logic [3:0] k);
		logic signed [1:0] d;
		unique case (k)
			4'd0, 4'd1, 4'd2: d = -2'sd1;
			4'd3, 4'd4, 4'd5: d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

	function automatic logic signed [1:0] dy_of(input logic [3:0] k);
		logic signed [1:0] d;
		unique case (k)
			4'd0, 4'd3, 4'd6: d = -2'sd1;
			4'd1, 4'd4, 4'd7: d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

endpackage

[rtl/greedy_gradient_route_walk.sv]
// Top level of the greedy gradient route walk: config registers, controller, datapath.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one word at a time. A load word
//   writes one gradient cell and leaves the controller idle, so loads stream one
//   per cycle. A plan word clamps start and target into the grid in use, walks
//   greedily to the best positive 8-neighbour, and then sends one res word per
//   row in use (res_valid/res_ready/res), row 0 first, last_row on the final one.
//   Each walk step is a mark/check state, nine reads of the grid store through
//   its single read port, a drain state and a move state. After the final
//   mark/check state the first row is loaded into the output register, then
//   one row per cycle while the receiver takes words; cmd_ready stays low until
//   the last row is in the output register.
//   A receiver stall holds the output register and pauses row emission.
//   Reset clears position, step count, bitmap and control; width and height
//   registers (APB, offsets 0 and 4) reset to 32. The grid store has no reset:
//   every cell a walk can read must be loaded first.
module greedy_gradient_route_walk #(
	parameter int GRID_W     = ggrw_pkg::GRID_W_DEF,
	parameter int GRID_H     = ggrw_pkg::GRID_H_DEF,
	parameter int VALUE_BITS = ggrw_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ggrw_pkg::in_word_t  cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output ggrw_pkg::out_word_t res
);
	import ggrw_pkg::*;

	logic [5:0] width_q, height_q;
	ctl_t ctl;
	sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {26'd0, height_q} : {26'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 6'd32;
			height_q <= 6'd32;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[5:0];
			end else begin
				height_q <= pwdata[5:0];
			end
		end
	end

	ggrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.opcode   (cmd.opcode),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	ggrw_dp #(
		.GRID_W    (GRID_W),
		.GRID_H    (GRID_H),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.width_raw (width_q),
		.height_raw(height_q),
		.ctl       (ctl),
		.sts       (sts),
		.res       (res)
	);

endmodule

[rtl/ggrw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ggrw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/ggrw_ctrl.sv]
// Controller state machine of the route walk.
module ggrw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  logic           opcode,
	output logic           res_valid,
	input  logic           res_ready,
	input  ggrw_pkg::sts_t sts,
	output ggrw_pkg::ctl_t ctl
);
	import ggrw_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MARK  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_MOVE  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (opcode == OP_LOAD) begin
						ctl.load = 1'b1;
					end else begin
						ctl.plan = 1'b1;
						state_d  = S_MARK;
					end
				end
			end
			S_MARK: begin
				if (sts.limit_hit) begin
					state_d = S_EMIT;
				end else begin
					ctl.mark = 1'b1;
					if (sts.at_target) begin
						ctl.set_reached = 1'b1;
						state_d         = S_EMIT;
					end else begin
						ctl.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_MOVE;
			S_MOVE: begin
				ctl.move = 1'b1;
				state_d  = S_MARK;
			end
			S_EMIT: begin
				if (out_free) begin
					ctl.emit_load = 1'b1;
					if (sts.row_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/ggrw_dp.sv]
// Datapath of the route walk: grid store, walk position, neighbour scan, bitmap.
module ggrw_dp #(
	parameter int GRID_W     = ggrw_pkg::GRID_W_DEF,
	parameter int GRID_H     = ggrw_pkg::GRID_H_DEF,
	parameter int VALUE_BITS = ggrw_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ggrw_pkg::in_word_t  cmd,
	input  logic [5:0]          width_raw,
	input  logic [5:0]          height_raw,
	input  ggrw_pkg::ctl_t      ctl,
	output ggrw_pkg::sts_t      sts,
	output ggrw_pkg::out_word_t res
);
	import ggrw_pkg::*;

	localparam int DEPTH = GRID_W * GRID_H;
	localparam int AW    = $clog2(DEPTH);
	localparam int NB    = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int CAP_W = (GRID_W < MAX_SIDE) ? GRID_W : MAX_SIDE;
	localparam int CAP_H = (GRID_H < MAX_SIDE) ? GRID_H : MAX_SIDE;

	logic [5:0] w, h;
	logic [4:0] sx, sy, tx, ty;
	logic [4:0] px_q, py_q, tx_q, ty_q;
	logic [10:0] count_q, limit_q;
	logic [MAX_SIDE-1:0] bitmap_q [MAX_SIDE];
	logic reached_q;
	logic [4:0] row_q;
	logic [3:0] k_q, k_s1, bk_q;
	logic vld_s1;
	logic signed [VALUE_BITS-1:0] best_q, rdata;
	logic signed [6:0] nx, ny;
	logic nb_ok;
	logic [4:0] nx5, ny5;
	logic ld_ok;
	logic [AW-1:0] waddr, raddr;
	logic [VALUE_BITS-1:0] wdata, rdata_raw;
	logic signed [5:0] mx, my;

	function automatic logic [5:0] clamp_size(input logic [5:0] v, input int cap);
		logic [5:0] r;
		if (v == 6'd0) begin
			r = 6'd1;
		end else if (int'(v) > cap) begin
			r = 6'(cap);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [4:0] clamp_coord(input logic [4:0] v, input logic [5:0] size);
		logic [4:0] r;
		if ({1'b0, v} >= size) begin
			r = 5'(size - 6'd1);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign w  = clamp_size(width_raw, CAP_W);
	assign h  = clamp_size(height_raw, CAP_H);
	assign sx = clamp_coord(cmd.start_x, w);
	assign sy = clamp_coord(cmd.start_y, h);
	assign tx = clamp_coord(cmd.target_x, w);
	assign ty = clamp_coord(cmd.target_y, h);

	// neighbour k of the current cell
	assign nx  = $signed({2'b00, px_q}) + 7'(dx_of(k_q));
	assign ny  = $signed({2'b00, py_q}) + 7'(dy_of(k_q));
	assign nb_ok = (nx >= 0) && (nx < $signed({1'b0, w})) && (ny >= 0)
		&& (ny < $signed({1'b0, h})) && (k_q != 4'(CENTER_K));
	assign nx5 = nx[4:0];
	assign ny5 = ny[4:0];

	assign ld_ok = (int'(cmd.cell_x) < GRID_W) && (int'(cmd.cell_y) < GRID_H);
	assign waddr = AW'(int'(cmd.cell_y) * GRID_W + int'(cmd.cell_x));
	assign raddr = AW'(int'(ny5) * GRID_W + int'(nx5));
	assign wdata = VALUE_BITS'($signed(cmd.gradient_value[NB-1:0]));
	assign rdata = $signed(rdata_raw);

	ggrw_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl.load && ld_ok),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.scan_step),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign mx = $signed({1'b0, px_q}) + 6'(dx_of(bk_q));
	assign my = $signed({1'b0, py_q}) + 6'(dy_of(bk_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q      <= '0;
			py_q      <= '0;
			tx_q      <= '0;
			ty_q      <= '0;
			count_q   <= '0;
			limit_q   <= '0;
			reached_q <= 1'b0;
			row_q     <= '0;
			k_q       <= '0;
			k_s1      <= '0;
			bk_q      <= 4'(CENTER_K);
			vld_s1    <= 1'b0;
			best_q    <= '0;
			for (int i = 0; i < MAX_SIDE; i++) begin
				bitmap_q[i] <= '0;
			end
		end else begin
			if (ctl.plan) begin
				px_q      <= sx;
				py_q      <= sy;
				tx_q      <= tx;
				ty_q      <= ty;
				count_q   <= '0;
				limit_q   <= 11'(w * h);
				reached_q <= 1'b0;
				row_q     <= '0;
				for (int i = 0; i < MAX_SIDE; i++) begin
					bitmap_q[i] <= '0;
				end
			end
			if (ctl.mark) begin
				for (int i = 0; i < MAX_SIDE; i++) begin
					if (5'(i) == py_q) begin
						bitmap_q[i][px_q] <= 1'b1;
					end
				end
			end
			if (ctl.set_reached) begin
				reached_q <= 1'b1;
			end
			if (ctl.scan_start) begin
				k_q    <= '0;
				best_q <= '0;
				bk_q   <= 4'(CENTER_K);
			end else if (ctl.scan_step) begin
				k_q <= k_q + 4'd1;
			end
			vld_s1 <= ctl.scan_step && nb_ok;
			k_s1   <= k_q;
			// strict compare keeps the first of equal values
			if (vld_s1 && (rdata > best_q)) begin
				best_q <= rdata;
				bk_q   <= k_s1;
			end
			if (ctl.move) begin
				px_q    <= mx[4:0];
				py_q    <= my[4:0];
				count_q <= count_q + 11'd1;
			end
			if (ctl.emit_load) begin
				row_q <= row_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_load) begin
			res.row_index      <= row_q;
			res.row_bits       <= bitmap_q[row_q];
			res.last_row       <= ({1'b0, row_q} == h - 6'd1);
			res.reached_target <= reached_q;
		end
	end

	assign sts.at_target = (px_q == tx_q) && (py_q == ty_q);
	assign sts.limit_hit = (count_q >= limit_q);
	assign sts.scan_last = (k_q == 4'(LAST_K));
	assign sts.row_last  = ({1'b0, row_q} == h - 6'd1);

endmodule
